// ----- design/spq_pkg.sv -----
// Package for the strict-priority task queue: sizes, codes, payload and control types.
`timescale 1ns / 1ps

package spq_pkg;

    // Queue organization.
    localparam int PRIORITY_LEVELS = 4;
    localparam int QUEUE_DEPTH     = 16;
    localparam int TASK_WIDTH      = 32;

    // Derived widths.
    localparam int LVL_W  = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS  = PRIORITY_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(SLOTS);

    // Operation codes carried in the mode field.
    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] task_value;
        logic [1:0]  priority_req;
    } spq_in_t;

    // Result transaction payload.
    typedef struct packed {
        logic [31:0] popped_task;
        logic [1:0]  status;
        logic        any_waiting;
        logic [1:0]  best_level;
    } spq_out_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } spq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
        logic load;
    } spq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_stall;
    } spq_stat_t;

endpackage

// ----- design/strict_priority_task_queue.sv -----
// Top level of the strict-priority task queue.
`timescale 1ns / 1ps

// Strict-priority task queue. Each input transaction pushes a task handle onto the FIFO of
// its priority level, pops the head of the most urgent non-empty FIFO, or clears all FIFOs,
// and produces exactly one result transaction with the popped handle (zero if none), a
// status code (ok, empty on a pop with nothing waiting, full on a dropped push), and the
// waiting flag and most urgent waiting level as they stand after the operation. A request
// level beyond the configured number of levels is treated as the least urgent level, and
// mode code 3 does nothing and reports ok. The block handles one transaction at a time:
// it accepts an input in its idle state, updates the queue pointers and reads or writes
// the task memory in its execute state, and loads the result register in its load state
// before it returns to idle, where it can accept the next input. The result register lets
// the next input be accepted while the previous result still waits to be taken; the queue
// then stalls only at the loading step. After reset all FIFOs are empty and the block is
// ready at once.

module strict_priority_task_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  spq_pkg::spq_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output spq_pkg::spq_out_t m_data
);

    // Command and status buses between the controller and the datapath.
    spq_pkg::spq_cmd_t  cmd;
    spq_pkg::spq_stat_t stat;

    // The controller sequences each transaction through capture, execute and load.
    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // The datapath owns the queue state, the task memory and the result register.
    spq_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- design/spq_ctrl.sv -----
// Controller state machine of the strict-priority task queue.
`timescale 1ns / 1ps

module spq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output spq_pkg::spq_cmd_t cmd,
    input  spq_pkg::spq_stat_t stat
);

    spq_pkg::spq_state_t state_reg;
    spq_pkg::spq_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        cmd.load    = 1'b0;
        case (state_reg)
            spq_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = spq_pkg::ST_EXEC;
                end
            end
            spq_pkg::ST_EXEC: begin
                cmd.execute = 1'b1;
                state_next  = spq_pkg::ST_LOAD;
            end
            spq_pkg::ST_LOAD: begin
                // Hold here until the output register can take the result.
                if (!stat.out_stall) begin
                    cmd.load   = 1'b1;
                    state_next = spq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/spq_datapath.sv -----
// Datapath of the strict-priority task queue: pointers, fill counts, task memory, result register.
`timescale 1ns / 1ps

module spq_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  spq_pkg::spq_cmd_t  cmd,
    output spq_pkg::spq_stat_t stat,
    input  spq_pkg::spq_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output spq_pkg::spq_out_t  m_data
);

    localparam int LEVELS = spq_pkg::PRIORITY_LEVELS;
    localparam int DEPTH  = spq_pkg::QUEUE_DEPTH;

    // Captured input transaction.
    spq_pkg::spq_in_t item_reg;

    // Per-level queue state.
    logic [spq_pkg::PTR_W-1:0] head_reg  [LEVELS];
    logic [spq_pkg::PTR_W-1:0] head_next [LEVELS];
    logic [spq_pkg::PTR_W-1:0] tail_reg  [LEVELS];
    logic [spq_pkg::PTR_W-1:0] tail_next [LEVELS];
    logic [spq_pkg::CNT_W-1:0] cnt_reg   [LEVELS];
    logic [spq_pkg::CNT_W-1:0] cnt_next  [LEVELS];

    // Per-item outcome held until the result is loaded.
    logic [1:0] status_reg;
    logic [1:0] status_next;
    logic       pop_hit_reg;
    logic       pop_hit_next;

    // Task memory with a registered read port.
    logic [spq_pkg::TASK_WIDTH-1:0] task_mem [spq_pkg::SLOTS];
    logic [spq_pkg::TASK_WIDTH-1:0] rd_data_reg;
    logic                           wr_en;
    logic                           rd_en;
    logic [spq_pkg::ADDR_W-1:0]     wr_addr;
    logic [spq_pkg::ADDR_W-1:0]     rd_addr;

    // Result register.
    logic              out_valid_reg;
    spq_pkg::spq_out_t out_data_reg;

    logic [spq_pkg::LVL_W-1:0] lvl;
    logic [spq_pkg::LVL_W-1:0] best;
    logic                      any;

    function automatic logic [spq_pkg::PTR_W-1:0] slot_inc(
        input logic [spq_pkg::PTR_W-1:0] p
    );
        if (p == spq_pkg::PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    function automatic logic [spq_pkg::ADDR_W-1:0] slot_addr(
        input logic [spq_pkg::LVL_W-1:0] l,
        input logic [spq_pkg::PTR_W-1:0] p
    );
        return spq_pkg::ADDR_W'(l) * spq_pkg::ADDR_W'(DEPTH) + spq_pkg::ADDR_W'(p);
    endfunction

    // Levels beyond the configured range fall into the least urgent level.
    assign lvl = (int'(item_reg.priority_req) >= LEVELS)
               ? spq_pkg::LVL_W'(LEVELS - 1)
               : spq_pkg::LVL_W'(item_reg.priority_req);

    // Priority encoder: most urgent non-empty level.
    always_comb begin
        any  = 1'b0;
        best = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (cnt_reg[i] != '0) begin
                any  = 1'b1;
                best = spq_pkg::LVL_W'(i);
            end
        end
    end

    assign wr_addr = slot_addr(lvl, tail_reg[lvl]);
    assign rd_addr = slot_addr(best, head_reg[best]);

    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        cnt_next     = cnt_reg;
        status_next  = status_reg;
        pop_hit_next = pop_hit_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        if (cmd.execute) begin
            status_next  = spq_pkg::STATUS_OK;
            pop_hit_next = 1'b0;
            case (item_reg.mode)
                spq_pkg::MODE_PUSH: begin
                    if (cnt_reg[lvl] == spq_pkg::CNT_W'(DEPTH)) begin
                        status_next = spq_pkg::STATUS_FULL;
                    end else begin
                        wr_en          = 1'b1;
                        tail_next[lvl] = slot_inc(tail_reg[lvl]);
                        cnt_next[lvl]  = cnt_reg[lvl] + 1'b1;
                    end
                end
                spq_pkg::MODE_POP: begin
                    if (!any) begin
                        status_next = spq_pkg::STATUS_EMPTY;
                    end else begin
                        rd_en          = 1'b1;
                        pop_hit_next   = 1'b1;
                        head_next[best] = slot_inc(head_reg[best]);
                        cnt_next[best]  = cnt_reg[best] - 1'b1;
                    end
                end
                spq_pkg::MODE_CLEAR: begin
                    for (int i = 0; i < LEVELS; i++) begin
                        head_next[i] = '0;
                        tail_next[i] = '0;
                        cnt_next[i]  = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            status_reg  <= spq_pkg::STATUS_OK;
            pop_hit_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            cnt_reg     <= cnt_next;
            status_reg  <= status_next;
            pop_hit_reg <= pop_hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            task_mem[wr_addr] <= spq_pkg::TASK_WIDTH'(item_reg.task_value);
        end
        if (rd_en) begin
            rd_data_reg <= task_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_data_reg.popped_task <= pop_hit_reg ? 32'(rd_data_reg) : '0;
            out_data_reg.status      <= status_reg;
            out_data_reg.any_waiting <= any;
            out_data_reg.best_level  <= 2'(best);
        end
    end

    assign stat.out_stall = out_valid_reg && !m_ready;
    assign m_valid        = out_valid_reg;
    assign m_data         = out_data_reg;

endmodule

// ----- tb/strict_priority_task_queue_tb.sv -----
// Testbench for the strict-priority task queue: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps

module strict_priority_task_queue_tb;
    import spq_pkg::*;

    // Mode code 3 is unused by the block; it must act as a no-op that reports ok.
    localparam logic [1:0] MODE_NOP = 2'd3;

    localparam int RANDOM_ITEMS = 600;
    // Cycles without any accepted transaction before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;
    // Quiet cycles after the last expected result, to catch stray extra results.
    localparam int DRAIN_CYCLES = 12;
    // The receiver's long hold-off: when it starts (cycles after reset) and how long it lasts.
    localparam int HOLD_START   = 300;
    localparam int HOLD_LEN     = 80;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    spq_in_t   s_data;
    logic      m_valid;
    logic      m_ready;
    spq_out_t  m_data;

    // Travels alongside s_data: when set, the accepted transaction is checked against
    // fixed_result, a value typed into the directed table, instead of the predictor.
    logic      use_fixed;
    spq_out_t  fixed_result;

    strict_priority_task_queue dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: one FIFO per level, held as a storage array with read and
    // write slots and an occupancy count, exactly as the queue keeps them.
    // ------------------------------------------------------------------------
    logic [TASK_WIDTH-1:0] task_mem [PRIORITY_LEVELS][QUEUE_DEPTH];
    int unsigned           rd_slot  [PRIORITY_LEVELS];
    int unsigned           wr_slot  [PRIORITY_LEVELS];
    int unsigned           held     [PRIORITY_LEVELS];

    // Results still owed by the block, oldest first.
    spq_out_t              pending_results[$];
    int                    error_count = 0;

    // Empties every FIFO. Storage contents are left alone, since only written
    // slots are ever read back.
    function automatic void empty_all_levels();
        for (int lv = 0; lv < PRIORITY_LEVELS; lv++) begin
            rd_slot[lv] = 0;
            wr_slot[lv] = 0;
            held[lv]    = 0;
        end
    endfunction

    // Returns the most urgent non-empty level, or PRIORITY_LEVELS when all are empty.
    function automatic int unsigned most_urgent_level();
        for (int lv = 0; lv < PRIORITY_LEVELS; lv++) begin
            if (held[lv] != 0) return lv;
        end
        return PRIORITY_LEVELS;
    endfunction

    // Applies one transaction to the predictor state and returns the result that
    // the block must produce for it.
    function automatic spq_out_t apply_task_op(input spq_in_t op);
        spq_out_t    res;
        int unsigned lv;
        int unsigned best;
        res = '0;
        // Requests beyond the last level fall back to the least urgent one.
        lv = op.priority_req;
        if (lv >= PRIORITY_LEVELS) lv = PRIORITY_LEVELS - 1;
        case (op.mode)
            MODE_PUSH: begin
                if (held[lv] >= QUEUE_DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    task_mem[lv][wr_slot[lv]] = op.task_value[TASK_WIDTH-1:0];
                    wr_slot[lv] = (wr_slot[lv] == QUEUE_DEPTH - 1) ? 0 : wr_slot[lv] + 1;
                    held[lv]++;
                end
            end
            MODE_POP: begin
                best = most_urgent_level();
                if (best >= PRIORITY_LEVELS) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    res.popped_task = 32'(task_mem[best][rd_slot[best]]);
                    rd_slot[best] = (rd_slot[best] == QUEUE_DEPTH - 1) ? 0 : rd_slot[best] + 1;
                    held[best]--;
                end
            end
            MODE_CLEAR: begin
                empty_all_levels();
            end
            default: begin
            end
        endcase
        best = most_urgent_level();
        if (best < PRIORITY_LEVELS) begin
            res.any_waiting = 1'b1;
            res.best_level  = 2'(best);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard. Both channels are sampled at the rising edge, where the values
    // seen are the ones that were stable before the edge. Results are checked
    // before new predictions are queued; a result can never belong to a
    // transaction accepted at the same edge, so the order is safe either way.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : scoreboard
        spq_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none, got %h",
                             $time, m_data);
                    error_count++;
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (m_data.popped_task !== want.popped_task) begin
                        $display("%0t: popped_task expected %h, got %h",
                                 $time, want.popped_task, m_data.popped_task);
                        error_count++;
                    end
                    if (m_data.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, m_data.status);
                        error_count++;
                    end
                    if (m_data.any_waiting !== want.any_waiting) begin
                        $display("%0t: any_waiting expected %b, got %b",
                                 $time, want.any_waiting, m_data.any_waiting);
                        error_count++;
                    end
                    if (m_data.best_level !== want.best_level) begin
                        $display("%0t: best_level expected %0d, got %0d",
                                 $time, want.best_level, m_data.best_level);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                // The predictor always runs so that its state tracks the block,
                // even on rows whose result is typed into the table.
                want = apply_task_op(s_data);
                if (use_fixed) want = fixed_result;
                pending_results.insert(pending_results.size(), want);
            end
        end
    end

    // Watchdog: any cycle with a transaction on either channel restarts the count.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (!aresetn) @(posedge aclk);
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver. It changes its stall style after each span of random length: always ready,
    // random coin flips, or ready one cycle in four. Once, it holds off for a long
    // stretch so that the result register and the in-flight slot fill up and the
    // block has to stall its input while the sender keeps offering.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int recv_cycles;
        int style;
        int span;
        recv_cycles = 0;
        m_ready = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            style = $urandom_range(0, 2);
            span  = $urandom_range(20, 80);
            repeat (span) begin
                @(posedge aclk);
                recv_cycles++;
                if (recv_cycles == HOLD_START) begin
                    m_ready <= 1'b0;
                    repeat (HOLD_LEN) @(posedge aclk);
                end
                case (style)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= (recv_cycles % 4 == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Transactions go out in bursts of random length; between bursts
    // valid drops for a random gap, and some bursts are long enough to give
    // stretches with no idling at all.
    // ------------------------------------------------------------------------
    int burst_left = 0;

    task automatic offer(input spq_in_t item, input bit fixed, input spq_out_t want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_data       <= item;
        use_fixed    <= fixed;
        fixed_result <= want;
        // s_ready read right after the edge is still the value the block presented
        // at that edge, so this loop exits on the edge that accepted the transaction.
        do @(posedge aclk); while (!s_ready);
    endtask

    typedef struct {
        spq_in_t  op;
        int       reps;    // Rows repeated more than once get a fresh random handle each time.
        bit       fixed;
        spq_out_t want;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic void add_row(input logic [1:0] mode, input logic [31:0] value,
                                    input logic [1:0] prio, input int reps,
                                    input bit fixed, input spq_out_t want);
        dir_row_t row;
        row.op    = '{mode: mode, task_value: value, priority_req: prio};
        row.reps  = reps;
        row.fixed = fixed;
        row.want  = want;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    initial begin : stimulus
        spq_in_t item;
        int      bias;
        int      focus;
        int      pick;
        int      push_share;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        use_fixed    = 1'b0;
        fixed_result = '0;
        empty_all_levels();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table. Typed results are those readable at a glance; the rest
        // go to the predictor (want left at zero).
        // Pop right after reset finds nothing.
        add_row(MODE_POP, 32'h0, 2'd0, 1, 1'b1, spq_out_t'{32'h0, STATUS_EMPTY, 1'b0, 2'd0});
        // The unused mode, with every other field at its maximum, does nothing.
        add_row(MODE_NOP, 32'hFFFF_FFFF, 2'd3, 1, 1'b1,
                spq_out_t'{32'h0, STATUS_OK, 1'b0, 2'd0});
        // Fill the least urgent level to the brim, then overflow it.
        add_row(MODE_PUSH, 32'hFFFF_FFFF, 2'd3, 1, 1'b1,
                spq_out_t'{32'h0, STATUS_OK, 1'b1, 2'd3});
        add_row(MODE_PUSH, 32'h0, 2'd3, QUEUE_DEPTH - 1, 1'b0, '0);
        add_row(MODE_PUSH, 32'h1234_5678, 2'd3, 1, 1'b1,
                spq_out_t'{32'h0, STATUS_FULL, 1'b1, 2'd3});
        // A more urgent task jumps ahead of the full level.
        add_row(MODE_PUSH, 32'h0, 2'd0, 1, 1'b1, spq_out_t'{32'h0, STATUS_OK, 1'b1, 2'd0});
        add_row(MODE_POP, 32'h0, 2'd0, 1, 1'b1, spq_out_t'{32'h0, STATUS_OK, 1'b1, 2'd3});
        add_row(MODE_POP, 32'h0, 2'd0, 1, 1'b1,
                spq_out_t'{32'hFFFF_FFFF, STATUS_OK, 1'b1, 2'd3});
        // Middle levels, served in order of urgency.
        add_row(MODE_PUSH, 32'hA5A5_A5A5, 2'd2, 1, 1'b1,
                spq_out_t'{32'h0, STATUS_OK, 1'b1, 2'd2});
        add_row(MODE_PUSH, 32'h5A5A_5A5A, 2'd1, 1, 1'b1,
                spq_out_t'{32'h0, STATUS_OK, 1'b1, 2'd1});
        add_row(MODE_POP, 32'h0, 2'd0, 1, 1'b1,
                spq_out_t'{32'h5A5A_5A5A, STATUS_OK, 1'b1, 2'd2});
        add_row(MODE_POP, 32'h0, 2'd0, 1, 1'b1,
                spq_out_t'{32'hA5A5_A5A5, STATUS_OK, 1'b1, 2'd3});
        // Clear drops the tasks still held on the least urgent level.
        add_row(MODE_CLEAR, 32'h0, 2'd0, 1, 1'b1, spq_out_t'{32'h0, STATUS_OK, 1'b0, 2'd0});
        add_row(MODE_POP, 32'h0, 2'd0, 1, 1'b1, spq_out_t'{32'h0, STATUS_EMPTY, 1'b0, 2'd0});

        foreach (dir_rows[i]) begin
            for (int r = 0; r < dir_rows[i].reps; r++) begin
                item = dir_rows[i].op;
                if (dir_rows[i].reps > 1) item.task_value = $urandom;
                offer(item, dir_rows[i].fixed, dir_rows[i].want);
            end
        end

        // Random traffic in phases: filling (mostly pushes, often aimed at one
        // level so that it overflows), draining (mostly pops, so empty pops
        // occur), and balanced. Clears and no-ops are sprinkled in as noise.
        bias  = 0;
        focus = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                bias  = $urandom_range(0, 2);
                focus = $urandom_range(0, PRIORITY_LEVELS - 1);
            end
            push_share = (bias == 0) ? 80 : (bias == 1) ? 30 : 55;
            pick = $urandom_range(0, 99);
            item.task_value = $urandom;
            if ($urandom_range(0, 15) == 0)
                item.task_value = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
            item.priority_req = ($urandom_range(0, 1) != 0) ? 2'(focus)
                                                            : 2'($urandom_range(0, 3));
            if (pick < 2)               item.mode = MODE_CLEAR;
            else if (pick < 5)          item.mode = MODE_NOP;
            else if (pick < push_share) item.mode = MODE_PUSH;
            else                        item.mode = MODE_POP;
            offer(item, 1'b0, '0);
        end

        // Wait for every owed result, then keep watching for a quiet stretch in
        // which any stray result would be flagged by the scoreboard.
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
